// File: hdl/torus_rank_coordinates_neighbors_defines.svh
// Assertion macros used by the checker file.
`ifndef TORUS_RANK_COORDINATES_NEIGHBORS_DEFINES_SVH
`define TORUS_RANK_COORDINATES_NEIGHBORS_DEFINES_SVH
// Implication checked on every rising clock edge, off during reset.
`define TRCN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication checked on every rising clock edge, also during reset.
`define TRCN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/trcn_pkg.sv
// -----------------------------------------------------------------------------
// trcn_pkg
// Shared widths, constants and types of the torus rank locator.
// -----------------------------------------------------------------------------
`default_nettype none
package trcn_pkg;
  localparam int unsigned RankW   = 16;
  localparam int unsigned ExtW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned Dims    = 3;
  localparam int unsigned MaxRanks = 65536;
  localparam int unsigned Stages  = RankW + 2;

  localparam logic [CfgIdxW-1:0] CfgExtX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExtY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgExtZ = 2'd2;

  // One item in flight in the divider chain.
  typedef struct packed {
    logic             vld;
    logic             oor;
    logic [RankW-1:0] rank;
    logic [RankW-1:0] rem;    // remainder field; the divider stages carry the running remainder
    logic [RankW-1:0] quo;    // quotient field; the divider stages build the quotient bits
    logic [RankW-1:0] cx;
    logic [RankW-1:0] cy;
    logic [RankW-1:0] cz;
  } item_t;
endpackage
`default_nettype wire

// File: hdl/torus_rank_coordinates_neighbors.sv
// Path from start to done_o: x divider, y divider, c_q, then the done_o register.
// Throughput: one rank per cycle; busy is always low outside reset.
// The depth is set by two chained one-bit-per-stage dividers (x, then y/z).
// Reset clears the extents to 1 and all valid bits; results appear only
// for ranks accepted after reset.
// -----------------------------------------------------------------------------
// torus_rank_coordinates_neighbors
// Periodic Cartesian grid locator: coordinates and neighbor ranks of a rank.
// -----------------------------------------------------------------------------
`default_nettype none
module torus_rank_coordinates_neighbors #(
  parameter int unsigned DIMS      = trcn_pkg::Dims,
  parameter int unsigned MAX_RANKS = trcn_pkg::MaxRanks
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [trcn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [trcn_pkg::ExtW-1:0]    cfg_data_i,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [trcn_pkg::RankW-1:0]   rank_i,
  output logic                              done_o,
  output logic [trcn_pkg::RankW-1:0]        coord_x_o,
  output logic [trcn_pkg::RankW-1:0]        coord_y_o,
  output logic [trcn_pkg::RankW-1:0]        coord_z_o,
  output logic [trcn_pkg::RankW-1:0]        left_x_o,
  output logic [trcn_pkg::RankW-1:0]        right_x_o,
  output logic [trcn_pkg::RankW-1:0]        left_y_o,
  output logic [trcn_pkg::RankW-1:0]        right_y_o,
  output logic [trcn_pkg::RankW-1:0]        left_z_o,
  output logic [trcn_pkg::RankW-1:0]        right_z_o,
  output logic                              out_of_range_o
);
  import trcn_pkg::*;
  localparam int unsigned ProdW = 3*ExtW;

  logic [ExtW-1:0] ext_q [3];
  logic [ExtW-1:0] ext   [3];
  logic [2*ExtW-1:0] exy_q;
  logic [ProdW-1:0]  tot_q;
  logic              big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) ext_q[i] <= ExtW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExtX: ext_q[0] <= cfg_data_i;
        CfgExtY: ext_q[1] <= cfg_data_i;
        CfgExtZ: ext_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      ext[i] = (i >= DIMS || ext_q[i] == '0) ? ExtW'(1) : ext_q[i];
  end

  // Grid size products, registered in turn: exy_q, tot_q, then the big_q flag.
  always_ff @(posedge clk_i) begin
    exy_q <= ext[0] * ext[1];
    tot_q <= exy_q * ext[2];
    big_q <= tot_q > ProdW'(MAX_RANKS);
  end

  assign busy = !rst_ni;

  // Stage 0: range check and launch of the x division.
  item_t a_d;
  always_comb begin
    a_d      = '0;
    a_d.vld  = start && !busy;
    a_d.oor  = big_q || (ProdW'(rank_i) >= tot_q);
    a_d.rank = rank_i;
  end

  item_t            bx;
  logic [RankW-1:0] qx, rx;
  trcn_divider u_div_x (
    .clk_i, .rst_ni, .divisor_i(ext[0]), .item_i(a_d), .dividend_i(rank_i),
    .item_o(bx), .quo_o(qx), .rem_o(rx)
  );

  // Quotient by x is divided by y: remainder is coord_y, quotient coord_z.
  item_t b_d;
  always_comb begin
    b_d    = bx;
    b_d.cx = rx;
  end
  item_t            cy;
  logic [RankW-1:0] qy, ry;
  trcn_divider u_div_y (
    .clk_i, .rst_ni, .divisor_i(ext[1]), .item_i(b_d), .dividend_i(qx),
    .item_o(cy), .quo_o(qy), .rem_o(ry)
  );

  // Stage: register coordinates, then form neighbors.
  item_t c_d;
  always_comb begin
    c_d    = cy;
    c_d.cy = ry;
    c_d.cz = qy;
  end
  item_t c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_q.vld <= 1'b0;
    else c_q <= c_d;
  end

  logic [RankW-1:0] str_y, str_z;
  assign str_y = RankW'(ext[0]);
  assign str_z = exy_q[RankW-1:0];

  function automatic logic [2*RankW-1:0] nbr(
    input logic [RankW-1:0] rank, input logic [RankW-1:0] c,
    input logic [ExtW-1:0] n, input logic [RankW-1:0] str,
    input logic [RankW-1:0] wrap);
    logic [RankW-1:0] lo, hi;
    if (n == ExtW'(1)) begin
      lo = rank; hi = rank;
    end else begin
      lo = (c == '0) ? rank + wrap : rank - str;
      hi = (ExtW'(c) == n - ExtW'(1)) ? rank - wrap : rank + str;
    end
    return {lo, hi};
  endfunction

  // Wrap distances (n-1)*stride, registered with the config products.
  logic [RankW-1:0] wx_q, wy_q, wz_q;
  always_ff @(posedge clk_i) begin
    wx_q <= RankW'(ext[0] - ExtW'(1));
    wy_q <= RankW'(exy_q - (2*ExtW)'(ext[0]));
    wz_q <= RankW'(tot_q - ProdW'(exy_q));
  end

  logic [2*RankW-1:0] nx, ny, nz;
  assign nx = nbr(c_q.rank, c_q.cx, ext[0], RankW'(1), wx_q);
  assign ny = nbr(c_q.rank, c_q.cy, ext[1], str_y, wy_q);
  assign nz = nbr(c_q.rank, c_q.cz, ext[2], str_z, wz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= c_q.vld;
  end
  always_ff @(posedge clk_i) begin
    out_of_range_o <= c_q.oor;
    coord_x_o <= c_q.oor ? '0 : c_q.cx;
    coord_y_o <= c_q.oor ? '0 : c_q.cy;
    coord_z_o <= c_q.oor ? '0 : c_q.cz;
    {left_x_o, right_x_o} <= c_q.oor ? '0 : nx;
    {left_y_o, right_y_o} <= c_q.oor ? '0 : ny;
    {left_z_o, right_z_o} <= c_q.oor ? '0 : nz;
  end
endmodule
`default_nettype wire

// File: hdl/trcn_div_stage.sv
// -----------------------------------------------------------------------------
// trcn_div_stage
// One registered restoring-division step: one quotient bit per stage.
// -----------------------------------------------------------------------------
`default_nettype none
module trcn_div_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [trcn_pkg::ExtW-1:0]  divisor_i,
  input  wire logic [trcn_pkg::RankW-1:0] dividend_i,
  input  wire logic [trcn_pkg::RankW-1:0] rem_i,
  input  wire logic [trcn_pkg::RankW-1:0] quo_i,
  input  wire logic [$clog2(trcn_pkg::RankW)-1:0] bit_i,
  output logic [trcn_pkg::RankW-1:0]      rem_o,
  output logic [trcn_pkg::RankW-1:0]      quo_o
);
  import trcn_pkg::*;
  logic [ExtW-1:0]  trial;
  logic             ge;
  logic [RankW-1:0] rem_d, rem_q, quo_d, quo_q;

  always_comb begin
    trial = {rem_i, dividend_i[bit_i]};
    ge    = trial >= divisor_i;
    rem_d = ge ? RankW'(trial - divisor_i) : trial[RankW-1:0];
    quo_d = quo_i;
    quo_d[bit_i] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end
  assign rem_o = rem_q;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// File: hdl/trcn_divider.sv
// -----------------------------------------------------------------------------
// trcn_divider
// Pipelined 16-bit by 17-bit divider with sideband, RankW+1 stages deep.
// -----------------------------------------------------------------------------
`default_nettype none
module trcn_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [trcn_pkg::ExtW-1:0]  divisor_i,
  input  wire trcn_pkg::item_t            item_i,
  input  wire logic [trcn_pkg::RankW-1:0] dividend_i,
  output trcn_pkg::item_t                 item_o,
  output logic [trcn_pkg::RankW-1:0]      quo_o,
  output logic [trcn_pkg::RankW-1:0]      rem_o
);
  import trcn_pkg::*;
  localparam int unsigned BitW = $clog2(RankW);
  item_t            side_q [RankW+1];
  logic [RankW-1:0] dvd_q  [RankW];
  logic [RankW-1:0] rem_w  [RankW+1];
  logic [RankW-1:0] quo_w  [RankW+1];

  assign rem_w[0] = '0;
  assign quo_w[0] = '0;

  // Unpiped divisor: user keeps it static with items in flight; unchecked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= RankW; i++) side_q[i].vld <= 1'b0;
    end else begin
      side_q[0] <= item_i;
      for (int i = 1; i <= RankW; i++) side_q[i] <= side_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    dvd_q[0] <= dividend_i;
    for (int i = 1; i < RankW; i++) dvd_q[i] <= dvd_q[i-1];
  end

  for (genvar g = 0; g < RankW; g++) begin : g_step
    trcn_div_stage u_stage (
      .clk_i, .rst_ni, .divisor_i,
      .dividend_i (dvd_q[g]),
      .rem_i      (rem_w[g]),
      .quo_i      (quo_w[g]),
      .bit_i      (BitW'(RankW-1-g)),
      .rem_o      (rem_w[g+1]),
      .quo_o      (quo_w[g+1])
    );
  end

  // Sideband lags by one extra register to line up with the step outputs.
  assign item_o = side_q[RankW];
  assign quo_o  = quo_w[RankW];
  assign rem_o  = rem_w[RankW];
endmodule
`default_nettype wire

// File: hdl/trcn_checker.sv
// -----------------------------------------------------------------------------
// trcn_checker
// Port-level checks of the torus rank locator, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "torus_rank_coordinates_neighbors_defines.svh"
module trcn_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       busy,
  input wire logic                       done_o,
  input wire logic                       out_of_range_o,
  input wire logic [trcn_pkg::RankW-1:0] coord_x_o,
  input wire logic [trcn_pkg::RankW-1:0] left_x_o
);
  import trcn_pkg::*;
  `TRCN_ASSERT(a_oor_zero, clk_i, rst_ni, done_o && out_of_range_o |-> coord_x_o == '0 && left_x_o == '0, "out of range result not cleared")
  `TRCN_ASSERT(a_never_busy, clk_i, rst_ni, !busy, "busy raised outside reset")
  `TRCN_ASSERT(a_no_spurious, clk_i, rst_ni, $rose(rst_ni) |-> !done_o, "result right after reset")
  `TRCN_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni && $past(!rst_ni) |-> !done_o, "result during reset")
endmodule

bind torus_rank_coordinates_neighbors trcn_checker u_trcn_checker (
  .clk_i, .rst_ni, .busy, .done_o, .out_of_range_o, .coord_x_o, .left_x_o
);
`default_nettype wire
